// ===== src/fasmd_pkg.sv =====
// Shared types, codes and constants for the float add/sub/mul/div unit.
// No dependencies; every other file uses it through scoped names.
package fasmd_pkg;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_PASS = 3'd4;

  localparam logic [1:0] RM_RTZ = 2'd0;
  localparam logic [1:0] RM_RNE = 2'd1;
  localparam logic [1:0] RM_RUP = 2'd2;
  localparam logic [1:0] RM_RDN = 2'd3;

  localparam logic CFG_FORMAT = 1'b0;
  localparam logic CFG_ROUND  = 1'b1;

  localparam int MANT_S = 23;
  localparam int MANT_H = 10;
  localparam int BIAS_S = 127;
  localparam int BIAS_H = 15;

  typedef enum logic [1:0] {CLS_ZERO, CLS_FIN, CLS_INF, CLS_NAN} fasmd_cls_t;

  // one queued operation; exponents are two's complement, value = sig * 2^q
  typedef struct packed {
    logic [2:0]  op;
    logic        fmt;
    logic [1:0]  rm;
    logic        special;
    logic [31:0] sres;
    logic        sa;
    logic        sb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [11:0] qa;
    logic [11:0] qb;
  } fasmd_item_t;

  function automatic logic [31:0] mk_nan(input logic fmt);
    return fmt ? 32'h0000_7E00 : 32'h7FC0_0000;
  endfunction

  function automatic logic [31:0] mk_inf(input logic fmt, input logic s);
    return fmt ? {16'h0, s, 15'h7C00} : {s, 31'h7F80_0000};
  endfunction

  function automatic logic [31:0] mk_max(input logic fmt, input logic s);
    return fmt ? {16'h0, s, 15'h7BFF} : {s, 31'h7F7F_FFFF};
  endfunction

  function automatic logic [31:0] mk_zero(input logic fmt, input logic s);
    return fmt ? {16'h0, s, 15'h0} : {s, 31'h0};
  endfunction

endpackage

// ===== src/fasmd_front.sv =====
// Front end: unpacks both operands, classifies them and resolves special cases.
// Depends on fasmd_pkg.
module fasmd_front (
  input  logic                  fmt,
  input  logic [1:0]            rm,
  input  logic [2:0]            opcode,
  input  logic [31:0]           operand_a,
  input  logic [31:0]           operand_b,
  output fasmd_pkg::fasmd_item_t item
);

  typedef struct packed {
    logic                  s;
    fasmd_pkg::fasmd_cls_t cls;
    logic [23:0]           sig;
    logic [11:0]           q;
  } opnd_t;

  function automatic opnd_t unpack(input logic f, input logic [31:0] bits);
    opnd_t       o;
    logic [22:0] frac;
    logic [7:0]  ef;
    logic        ones;
    logic [11:0] off;
    if (f) begin
      frac = {13'h0, bits[9:0]};
      ef   = {3'h0, bits[14:10]};
      ones = (bits[14:10] == 5'h1F);
      o.s  = bits[15];
      off  = 12'(fasmd_pkg::BIAS_H + fasmd_pkg::MANT_H);
      o.sig = {13'h0, (ef != 8'h0), frac[9:0]};
    end else begin
      frac = bits[22:0];
      ef   = bits[30:23];
      ones = (bits[30:23] == 8'hFF);
      o.s  = bits[31];
      off  = 12'(fasmd_pkg::BIAS_S + fasmd_pkg::MANT_S);
      o.sig = {(ef != 8'h0), frac};
    end
    if (ones)
      o.cls = (frac != 23'h0) ? fasmd_pkg::CLS_NAN : fasmd_pkg::CLS_INF;
    else if (ef == 8'h0)
      o.cls = (frac != 23'h0) ? fasmd_pkg::CLS_FIN : fasmd_pkg::CLS_ZERO;
    else
      o.cls = fasmd_pkg::CLS_FIN;
    o.q = ((ef == 8'h0) ? 12'd1 : {4'h0, ef}) - off;
    return o;
  endfunction

  opnd_t       ua, ub;
  logic [31:0] a_m, b_m;
  logic        sbe, sx;
  logic        any_nan;

  always_comb begin
    a_m = fmt ? {16'h0, operand_a[15:0]} : operand_a;
    b_m = fmt ? {16'h0, operand_b[15:0]} : operand_b;
    ua  = unpack(fmt, a_m);
    ub  = unpack(fmt, b_m);
    sbe = ub.s ^ (opcode == fasmd_pkg::OP_SUB);
    sx  = ua.s ^ ub.s;
    any_nan = (ua.cls == fasmd_pkg::CLS_NAN) || (ub.cls == fasmd_pkg::CLS_NAN);

    item.op      = opcode;
    item.fmt     = fmt;
    item.rm      = rm;
    item.special = 1'b1;
    item.sres    = 32'h0;
    item.sa      = ua.s;
    item.sb      = ub.s;
    item.ma      = ua.sig;
    item.mb      = ub.sig;
    item.qa      = ua.q;
    item.qb      = ub.q;

    case (opcode)
      fasmd_pkg::OP_ADD, fasmd_pkg::OP_SUB: begin
        item.sb = sbe;
        if (any_nan || (ua.cls == fasmd_pkg::CLS_INF && ub.cls == fasmd_pkg::CLS_INF &&
                        ua.s != sbe))
          item.sres = fasmd_pkg::mk_nan(fmt);
        else if (ua.cls == fasmd_pkg::CLS_INF)
          item.sres = fasmd_pkg::mk_inf(fmt, ua.s);
        else if (ub.cls == fasmd_pkg::CLS_INF)
          item.sres = fasmd_pkg::mk_inf(fmt, sbe);
        else
          item.special = 1'b0;
      end
      fasmd_pkg::OP_MUL: begin
        if (any_nan ||
            (ua.cls == fasmd_pkg::CLS_INF && ub.cls == fasmd_pkg::CLS_ZERO) ||
            (ua.cls == fasmd_pkg::CLS_ZERO && ub.cls == fasmd_pkg::CLS_INF))
          item.sres = fasmd_pkg::mk_nan(fmt);
        else if (ua.cls == fasmd_pkg::CLS_INF || ub.cls == fasmd_pkg::CLS_INF)
          item.sres = fasmd_pkg::mk_inf(fmt, sx);
        else if (ua.cls == fasmd_pkg::CLS_ZERO || ub.cls == fasmd_pkg::CLS_ZERO)
          item.sres = fasmd_pkg::mk_zero(fmt, sx);
        else
          item.special = 1'b0;
      end
      fasmd_pkg::OP_DIV: begin
        if (any_nan ||
            (ua.cls == fasmd_pkg::CLS_ZERO && ub.cls == fasmd_pkg::CLS_ZERO) ||
            (ua.cls == fasmd_pkg::CLS_INF && ub.cls == fasmd_pkg::CLS_INF))
          item.sres = fasmd_pkg::mk_nan(fmt);
        else if (ua.cls == fasmd_pkg::CLS_INF || ub.cls == fasmd_pkg::CLS_ZERO)
          item.sres = fasmd_pkg::mk_inf(fmt, sx);
        else if (ua.cls == fasmd_pkg::CLS_ZERO || ub.cls == fasmd_pkg::CLS_INF)
          item.sres = fasmd_pkg::mk_zero(fmt, sx);
        else
          item.special = 1'b0;
      end
      fasmd_pkg::OP_PASS: begin
        item.sres = (ua.cls == fasmd_pkg::CLS_NAN) ? fasmd_pkg::mk_nan(fmt) : a_m;
      end
      default: item.sres = 32'h0;
    endcase
  end

endmodule

// ===== src/fasmd_queue.sv =====
// Two-entry queue between the front end and the execution back end.
// Depends on fasmd_pkg.
module fasmd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  fasmd_pkg::fasmd_item_t push_item,
  output logic                   full,
  input  logic                   pop,
  output logic                   nonempty,
  output fasmd_pkg::fasmd_item_t pop_item
);

  fasmd_pkg::fasmd_item_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push)
      slots[wr_ptr] <= push_item;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push)
        wr_ptr <= ~wr_ptr;
      if (pop)
        rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/fasmd_back.sv =====
// Back end: sequencer for align/add, multiply, radix-2 divide, normalize and round.
// Depends on fasmd_pkg.
module fasmd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  fasmd_pkg::fasmd_item_t q_item,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ALIGN, ST_ADD, ST_MUL, ST_DNORM, ST_DIV, ST_NORM, ST_RND1, ST_RND2, ST_DONE
  } state_t;

  state_t             state;
  logic               fmt, sa, sb, s;
  logic [1:0]         rm;
  logic [23:0]        ma, mb;
  logic signed [11:0] qa, qb, q, e;
  logic [60:0]        x, y;
  logic [63:0]        sig;
  logic [25:0]        rem;
  logic [26:0]        quo;
  logic [4:0]         cnt;
  logic [24:0]        kept;
  logic               rb, st;
  logic [31:0]        res;

  // align
  logic               swap, hs, ls;
  logic [23:0]        hm, lm;
  logic signed [11:0] hq, lq, d;
  logic [60:0]        x_next, y_next;
  logic signed [11:0] q_align;
  // add
  logic [60:0]        sum;
  logic               s_add;
  // divide
  logic [25:0]        trial, r2;
  logic               qbit, ha, hb;
  // round
  logic signed [11:0] e0, emin, ec, sh, mbits, bias, e2;
  logic [6:0]         shi;
  logic [5:0]         rbi;
  logic [24:0]        kept_next;
  logic               rb_next, st_next, inc;
  logic [25:0]        k1, k2;
  logic [31:0]        packed_res;

  assign q_pop = (state == ST_IDLE) && q_valid;

  always_comb begin
    mbits = fmt ? 12'sd10 : 12'sd23;
    bias  = fmt ? 12'sd15 : 12'sd127;
    emin  = 12'sd1 - bias;

    swap = (qa < qb);
    hm = swap ? mb : ma;  lm = swap ? ma : mb;
    hq = swap ? qb : qa;  lq = swap ? qa : qb;
    hs = swap ? sb : sa;  ls = swap ? sa : sb;
    d  = hq - lq;
    if (d <= 12'sd36) begin
      x_next  = 61'(hm) << d[5:0];
      y_next  = 61'(lm);
      q_align = lq;
    end else begin
      // far apart: the small operand only acts as a sticky bit
      x_next  = 61'(hm) << 8;
      y_next  = 61'(lm != 24'h0);
      q_align = hq - 12'sd8;
    end

    if (sa == sb) begin
      sum = x + y;  s_add = sa;
    end else if (x > y) begin
      sum = x - y;  s_add = sa;
    end else begin
      sum = y - x;  s_add = sb;
    end

    ha    = fmt ? ma[10] : ma[23];
    hb    = fmt ? mb[10] : mb[23];
    trial = rem - 26'(mb);
    qbit  = (rem >= 26'(mb));
    r2    = qbit ? trial : rem;

    // sig has bit 63 set here
    e0 = q + 12'sd63;
    ec = (e0 < emin) ? emin : e0;
    sh = ec - mbits - q;
    shi = 7'(sh);
    rbi = 6'(shi - 7'd1);
    if (sh > 12'sd64) begin
      kept_next = 25'h0;
      rb_next   = 1'b0;
      st_next   = 1'b1;
    end else begin
      kept_next = 25'(sig >> shi);
      rb_next   = sig[rbi];
      st_next   = |(sig & ~({64{1'b1}} << rbi));
    end

    case (rm)
      fasmd_pkg::RM_RNE: inc = rb && (st || kept[0]);
      fasmd_pkg::RM_RUP: inc = !s && (rb || st);
      fasmd_pkg::RM_RDN: inc = s && (rb || st);
      default:           inc = 1'b0;
    endcase
    k1 = 26'(kept) + 26'(inc);
    if (fmt ? k1[11] : k1[24]) begin
      k2 = k1 >> 1;
      e2 = e + 12'sd1;
    end else begin
      k2 = k1;
      e2 = e;
    end
    if (e2 > bias) begin
      if (rm == fasmd_pkg::RM_RNE || (rm == fasmd_pkg::RM_RUP && !s) ||
          (rm == fasmd_pkg::RM_RDN && s))
        packed_res = fasmd_pkg::mk_inf(fmt, s);
      else
        packed_res = fasmd_pkg::mk_max(fmt, s);
    end else if (fmt) begin
      packed_res = {16'h0, s, (k2[10] ? 5'(e2 + bias) : 5'h0), k2[9:0]};
    end else begin
      packed_res = {s, (k2[23] ? 8'(e2 + bias) : 8'h0), k2[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE)
        m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            fmt <= q_item.fmt;
            rm  <= q_item.rm;
            sa  <= q_item.sa;
            sb  <= q_item.sb;
            ma  <= q_item.ma;
            mb  <= q_item.mb;
            qa  <= $signed(q_item.qa);
            qb  <= $signed(q_item.qb);
            res <= q_item.sres;
            if (q_item.special)
              state <= ST_DONE;
            else if (q_item.op == fasmd_pkg::OP_MUL)
              state <= ST_MUL;
            else if (q_item.op == fasmd_pkg::OP_DIV)
              state <= ST_DNORM;
            else
              state <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          x  <= x_next;
          y  <= y_next;
          q  <= q_align;
          sa <= hs;
          sb <= ls;
          state <= ST_ADD;
        end
        ST_ADD: begin
          if (sum == 61'h0) begin
            res <= fasmd_pkg::mk_zero(fmt, (sa == sb) ? sa : (rm == fasmd_pkg::RM_RDN));
            state <= ST_DONE;
          end else begin
            sig   <= 64'(sum);
            s     <= s_add;
            state <= ST_NORM;
          end
        end
        ST_MUL: begin
          sig   <= 64'(48'(ma) * 48'(mb));
          q     <= qa + qb;
          s     <= sa ^ sb;
          state <= ST_NORM;
        end
        ST_DNORM: begin
          if (!ha) begin
            ma <= ma << 1;
            qa <= qa - 12'sd1;
          end
          if (!hb) begin
            mb <= mb << 1;
            qb <= qb - 12'sd1;
          end
          if (ha && hb) begin
            rem   <= 26'(ma);
            quo   <= 27'h0;
            cnt   <= fmt ? 5'd14 : 5'd27;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo <= {quo[25:0], qbit};
          rem <= {r2[24:0], 1'b0};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            sig   <= {36'h0, quo[25:0], qbit, (r2 != 26'h0)};
            q     <= qa - qb - (fmt ? 12'sd14 : 12'sd27);
            s     <= sa ^ sb;
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (sig[63:56] == 8'h0) begin
            sig <= sig << 8;
            q   <= q - 12'sd8;
          end else if (!sig[63]) begin
            sig <= sig << 1;
            q   <= q - 12'sd1;
          end else begin
            state <= ST_RND1;
          end
        end
        ST_RND1: begin
          kept  <= kept_next;
          rb    <= rb_next;
          st    <= st_next;
          e     <= ec;
          state <= ST_RND2;
        end
        ST_RND2: begin
          res   <= packed_res;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/float_add_sub_mul_div_unit.sv =====
// Top level of the IEEE 754 binary32/binary16 add, subtract, multiply, divide unit.
// Depends on fasmd_pkg, fasmd_front, fasmd_queue and fasmd_back.
//
// One transfer in gives one correctly rounded result out, in order. The front
// end classifies operands and resolves NaN, infinity, zero, pass and unused
// opcodes at once; a two-entry queue feeds the back-end sequencer, which works
// on one item at a time. From leaving the queue, results settled in the front
// end go straight to output; an exact zero sum goes out after align and add;
// add/subtract runs align, add, normalize and round; multiply runs multiply,
// normalize and round; divide runs operand normalize (one bit per step until
// both leading bits are set), one quotient bit per cycle (27 quotient bits in
// binary32, 14 in binary16), normalize and round. Normalize shifts by a byte
// or a bit per step. A result waiting on m_tready holds the sequencer.
// Configuration: index 0 format_select (0 binary32, 1 binary16 in low bits),
// index 1 rounding_mode (0 toward zero, 1 nearest even, 2 up, 3 down); write it
// only while no transfer is in flight. binary16 results are zero-extended.
module float_add_sub_mul_div_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [2:0] opcode, [34:3] operand_a, [66:35] operand_b
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] result_bits
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  logic                   format_select;
  logic [1:0]             rounding_mode;
  logic                   q_full, q_nonempty, q_pop, push;
  fasmd_pkg::fasmd_item_t front_item, back_item;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign push      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_select <= 1'b0;
      rounding_mode <= fasmd_pkg::RM_RNE;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == fasmd_pkg::CFG_FORMAT)
        format_select <= cfg_data[0];
      else
        rounding_mode <= cfg_data;
    end
  end

  fasmd_front u_front (
    .fmt       (format_select),
    .rm        (rounding_mode),
    .opcode    (s_tdata[2:0]),
    .operand_a (s_tdata[34:3]),
    .operand_b (s_tdata[66:35]),
    .item      (front_item)
  );

  fasmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_item  (back_item)
  );

  fasmd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_nonempty),
    .q_item   (back_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== src/fasmd_checker.sv =====
// Port-level checker for float_add_sub_mul_div_unit, bound to the top level.
// Depends on fasmd_pkg.
module fasmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_index,
  input logic [1:0]  cfg_data
);

  logic fmt_shadow;

  always_ff @(posedge clk) begin
    if (rst)
      fmt_shadow <= 1'b0;
    else if (cfg_valid && cfg_ready && cfg_index == fasmd_pkg::CFG_FORMAT)
      fmt_shadow <= cfg_data[0];
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_half_ext: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && fmt_shadow |-> m_tdata[31:16] == 16'h0)
    else $error("binary16 result not zero-extended");

  a_nan_canon: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !fmt_shadow && m_tdata[30:23] == 8'hFF |->
      m_tdata[22:0] == 23'h0 || m_tdata == 32'h7FC0_0000)
    else $error("non-canonical NaN");

endmodule

bind float_add_sub_mul_div_unit fasmd_checker u_fasmd_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
